@@ rtl/tccs_pkg.sv @@
// shared types and constants for the text console cursor/scroll core
// no dependencies; the other files that use it refer to it by scoped names
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int CMD_DEPTH   = 2;
    localparam int RES_DEPTH   = 2;

    localparam logic [15:0] BLANK_CELL = 16'h0F20;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7F;

    localparam int TAB_STOP = 8;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRINT,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [3:0]  bg_color;
        logic [3:0]  fg_color;
        logic [10:0] cell_address;
    } in_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_addr;
        logic [15:0] cell_data;
        logic        scrolled;
    } res_t;

    // classified command as queued between front and back
    typedef struct packed {
        op_t         op;
        logic [15:0] cell_word;
        logic [10:0] addr;
        logic        addr_ok;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } front_out_t;

    typedef struct packed {
        logic cmd_pop;
        logic init_busy;
    } fb_t;

endpackage

@@ rtl/tccs_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tccs_fifo.sv @@
// small register fifo used for the command and result queues
// no dependencies
`timescale 1ns / 1ps

module tccs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/tccs_front.sv @@
// front end: accepts input items, classifies them, queues the commands
// depends on tccs_pkg and tccs_fifo
`timescale 1ns / 1ps

module tccs_front #(
    parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tccs_pkg::in_t        item,
    input  logic                 push,
    output logic                 full,
    input  tccs_pkg::fb_t        link,
    output tccs_pkg::front_out_t fq
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CMDW  = $bits(tccs_pkg::cmd_t);

    tccs_pkg::cmd_t  cmd;
    logic            q_full, q_empty;
    logic [CMDW-1:0] q_rdata;

    always_comb
    begin
        cmd.cell_word = {item.bg_color, item.fg_color, item.char_code};
        cmd.addr      = item.cell_address;
        cmd.addr_ok   = (32'(item.cell_address) < CELLS);
        unique case (item.func)
            tccs_pkg::FUNC_PUT:
            begin
                unique case (item.char_code) inside
                    tccs_pkg::CH_BS:                       cmd.op = tccs_pkg::OP_BS;
                    tccs_pkg::CH_TAB:                      cmd.op = tccs_pkg::OP_TAB;
                    tccs_pkg::CH_LF:                       cmd.op = tccs_pkg::OP_LF;
                    tccs_pkg::CH_CR:                       cmd.op = tccs_pkg::OP_CR;
                    [tccs_pkg::CH_SPACE:tccs_pkg::CH_LAST]: cmd.op = tccs_pkg::OP_PRINT;
                    default:                               cmd.op = tccs_pkg::OP_NOP;
                endcase
            end
            tccs_pkg::FUNC_CLEAR: cmd.op = tccs_pkg::OP_CLEAR;
            tccs_pkg::FUNC_READ:  cmd.op = tccs_pkg::OP_READ;
            default:              cmd.op = tccs_pkg::OP_NOP;
        endcase
    end

    // no transfer while the store is swept after reset
    assign full = q_full || link.init_busy;

    tccs_fifo #(
        .WIDTH(CMDW),
        .DEPTH(tccs_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push && !full),
        .wdata(cmd),
        .full (q_full),
        .pop  (link.cmd_pop),
        .rdata(q_rdata),
        .empty(q_empty)
    );

    assign fq.valid = !q_empty;
    assign fq.cmd   = tccs_pkg::cmd_t'(q_rdata);

endmodule

@@ rtl/tccs_back.sv @@
// back end: cursor registers, screen store and the fill/scroll sequencer
// depends on tccs_pkg and tccs_ram
`timescale 1ns / 1ps

module tccs_back #(
    parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tccs_pkg::front_out_t fq,
    output tccs_pkg::fb_t        link,
    input  logic                 res_full,
    output logic                 res_push,
    output tccs_pkg::res_t       res
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int LW    = CNTW;
    localparam int CW    = $clog2(COLUMNS + tccs_pkg::TAB_STOP);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int TB    = $clog2(tccs_pkg::TAB_STOP);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_BLANK  = 6'b010000,
        S_CLEAR  = 6'b100000
    } bstate_t;

    bstate_t         state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [LW-1:0]   loc_reg, loc_next;
    logic            rd_ok_reg, rd_ok_next;
    logic            copy_vld_reg, copy_vld_next;
    logic [AW-1:0]   copy_dst_reg, copy_dst_next;

    logic            cmd_go;
    logic [CW-1:0]   col_put, col_new, tab_sum;
    logic            line_up, wrap, newline, scroll_hit;
    logic [RW-1:0]   row_inc, row_new;
    logic [LW-1:0]   line_base, loc_new;

    logic            we, re;
    logic [AW-1:0]   waddr, raddr;
    logic [15:0]     wdata, rdata;

    assign cmd_go = (state_reg == S_IDLE) && fq.valid && !res_full;

    // cursor motion for a put; loc tracks row*COLUMNS+col without a multiplier
    always_comb
    begin
        tab_sum = col_reg + CW'(tccs_pkg::TAB_STOP);
        col_put = col_reg;
        line_up = 1'b0;
        unique case (fq.cmd.op)
            tccs_pkg::OP_PRINT: col_put = col_reg + CW'(1);
            tccs_pkg::OP_BS:    col_put = (col_reg == '0) ? col_reg : col_reg - CW'(1);
            tccs_pkg::OP_TAB:   col_put = {tab_sum[CW-1:TB], TB'(0)};
            tccs_pkg::OP_CR:    col_put = '0;
            tccs_pkg::OP_LF:
            begin
                col_put = '0;
                line_up = 1'b1;
            end
            default:            col_put = col_reg;
        endcase
        wrap       = (col_put >= CW'(COLUMNS));
        newline    = line_up || wrap;
        col_new    = newline ? '0 : col_put;
        row_inc    = row_reg + RW'(1);
        scroll_hit = newline && (row_inc == RW'(ROWS));
        row_new    = newline ? (scroll_hit ? RW'(ROWS - 1) : row_inc) : row_reg;
        line_base  = loc_reg - LW'(col_reg);
        if (scroll_hit)
        begin
            loc_new = LW'((ROWS - 1) * COLUMNS);
        end
        else if (newline)
        begin
            loc_new = line_base + LW'(COLUMNS);
        end
        else
        begin
            loc_new = line_base + LW'(col_new);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        loc_next       = loc_reg;
        rd_ok_next     = rd_ok_reg;
        copy_vld_next  = copy_vld_reg;
        copy_dst_next  = copy_dst_reg;
        we             = 1'b0;
        waddr          = cnt_reg[AW-1:0];
        wdata          = tccs_pkg::BLANK_CELL;
        re             = 1'b0;
        raddr          = cnt_reg[AW-1:0];
        res_push       = 1'b0;
        link.cmd_pop   = 1'b0;
        link.init_busy = (state_reg == S_INIT);

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg == CNTW'(CELLS - 1))
                begin
                    res_push   = (state_reg == S_CLEAR);
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            S_IDLE:
            begin
                if (cmd_go)
                begin
                    link.cmd_pop = 1'b1;
                    unique case (fq.cmd.op)
                        tccs_pkg::OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            loc_next   = '0;
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        tccs_pkg::OP_READ:
                        begin
                            re         = 1'b1;
                            raddr      = AW'(fq.cmd.addr);
                            rd_ok_next = fq.cmd.addr_ok;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            col_next = col_new;
                            row_next = row_new;
                            loc_next = loc_new;
                            if (fq.cmd.op == tccs_pkg::OP_PRINT)
                            begin
                                we    = 1'b1;
                                waddr = loc_reg[AW-1:0];
                                wdata = fq.cmd.cell_word;
                            end
                            if (scroll_hit)
                            begin
                                cnt_next      = CNTW'(COLUMNS);
                                copy_vld_next = 1'b0;
                                state_next    = S_SCROLL;
                            end
                            else
                            begin
                                res_push = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_push   = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                // read one row down; the registered read data is written one row up
                if (copy_vld_reg)
                begin
                    we    = 1'b1;
                    waddr = copy_dst_reg;
                    wdata = rdata;
                end
                if (cnt_reg != CNTW'(CELLS))
                begin
                    re            = 1'b1;
                    copy_vld_next = 1'b1;
                    copy_dst_next = AW'(cnt_reg - CNTW'(COLUMNS));
                    cnt_next      = cnt_reg + CNTW'(1);
                end
                else
                begin
                    copy_vld_next = 1'b0;
                    cnt_next      = CNTW'((ROWS - 1) * COLUMNS);
                    state_next    = S_BLANK;
                end
            end
            S_BLANK:
            begin
                we = 1'b1;
                if (cnt_reg == CNTW'(CELLS - 1))
                begin
                    res_push   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.cursor_col  = 7'(col_next);
        res.cursor_row  = 5'(row_next);
        res.cursor_addr = 11'(loc_next);
        res.cell_data   = ((state_reg == S_READ) && rd_ok_reg) ? rdata : 16'h0000;
        res.scrolled    = (state_reg == S_BLANK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            loc_reg      <= '0;
            rd_ok_reg    <= 1'b0;
            copy_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            loc_reg      <= loc_next;
            rd_ok_reg    <= rd_ok_next;
            copy_vld_reg <= copy_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_dst_reg <= copy_dst_next;
    end

    tccs_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_screen (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < ROWS)
        else $error("cursor row out of range");

    a_loc_track: assert property (@(posedge clk) disable iff (!rst_n)
        32'(loc_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg))
        else $error("cursor location out of step with row and column");

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        link.cmd_pop |=> (state_reg != S_INIT))
        else $error("command taken during the reset sweep");

endmodule

@@ rtl/text_console_cursor_scroll_core.sv @@
// top level of the text console cursor/scroll core
// depends on tccs_pkg, tccs_front, tccs_back, tccs_fifo
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------
//   command   | push / full        | item   (tccs_pkg::in_t)
//   result    | pop / empty        | result (tccs_pkg::res_t)
//
// put and ignored bytes are done in the idle state, a read adds a registered store read
// clear blanks all COLUMNS*ROWS cells, a scrolling put copies COLUMNS*(ROWS-1) cells one row up
// and then blanks the last row of COLUMNS cells, all through the one store write port
// after reset the store is swept to blank with full high
// a two-entry command queue and a two-entry result queue let each side stall alone
`timescale 1ns / 1ps

module text_console_cursor_scroll_core #(
    parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tccs_pkg::in_t  item,
    input  logic           push,
    output logic           full,
    output tccs_pkg::res_t result,
    output logic           empty,
    input  logic           pop
);

    localparam int RESW = $bits(tccs_pkg::res_t);

    tccs_pkg::front_out_t fq;
    tccs_pkg::fb_t        link;
    tccs_pkg::res_t       res;
    logic                 res_push, res_full;
    logic [RESW-1:0]      res_rdata;

    tccs_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .item (item),
        .push (push),
        .full (full),
        .link (link),
        .fq   (fq)
    );

    tccs_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .fq      (fq),
        .link    (link),
        .res_full(res_full),
        .res_push(res_push),
        .res     (res)
    );

    tccs_fifo #(
        .WIDTH(RESW),
        .DEPTH(tccs_pkg::RES_DEPTH)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res),
        .full (res_full),
        .pop  (pop),
        .rdata(res_rdata),
        .empty(empty)
    );

    assign result = tccs_pkg::res_t'(res_rdata);

endmodule
